// ----- src/fxe_pkg.sv -----
// ----------------------------------------------------------------------------
// fxe_pkg
// Shared types and constants for the float xor stream encoder: transfer
// payloads, the codeword queue entry and the packing widths.
// ----------------------------------------------------------------------------
package fxe_pkg;

    // longest codeword: 2 control bits, 5-bit lead, 5-bit length, 32 bits
    localparam int CODE_W = 44;
    // codeword length field, 1 to 44
    localparam int LEN_W = 6;
    // accumulator: up to 7 leftover bits plus one full codeword
    localparam int ACC_W = CODE_W + 7;
    // pending bit count, 0 to 51
    localparam int PEND_W = 6;
    // window bounds and zero counts, 0 to 32
    localparam int ZC_W = 6;
    localparam logic [ZC_W-1:0] NO_WINDOW = ZC_W'(32);

    // byte counter and capacity register
    localparam int CNT_W = 16;
    localparam logic [CNT_W-1:0] CAPACITY_RESET = 16'hFFFF;

    // default depth of the codeword queue
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // configuration bus
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic [0:0] REG_OUTPUT_CAPACITY = 1'b0;

    // input transfer
    typedef struct packed {
        logic [31:0] value_bits;
        logic        block_start;
        logic        block_end;
    } in_t;

    // output transfer
    typedef struct packed {
        logic [7:0]       out_byte;
        logic             byte_valid;
        logic             block_done;
        logic [CNT_W-1:0] byte_count;
        logic             too_small;
    } out_t;

    // one classified item waiting for the packer
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
        logic              block_start;
        logic              block_end;
    } entry_t;

endpackage

// ----- src/fxe_front.sv -----
// ----------------------------------------------------------------------------
// fxe_front
// Front end: accepts values, xors against the previous one, tracks the
// leading/trailing-zero window and builds one codeword per value.
// ----------------------------------------------------------------------------
module fxe_front
    import fxe_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_stall,
    input  in_t    in_data,
    output logic   push,
    output entry_t push_data,
    input  logic   queue_full
);

    logic [31:0]     prev_reg;
    logic [31:0]     prev_next;
    logic [ZC_W-1:0] win_lead_reg;
    logic [ZC_W-1:0] win_lead_next;
    logic [ZC_W-1:0] win_trail_reg;
    logic [ZC_W-1:0] win_trail_next;

    logic [31:0]     xor_val;
    logic [ZC_W-1:0] lz;
    logic [ZC_W-1:0] tz;
    logic [ZC_W-1:0] mean_len;
    logic [ZC_W-1:0] win_len;
    logic            win_hit;
    logic            new_window;

    // leading zeros of a non-zero word, halving search
    function automatic logic [ZC_W-1:0] count_lead(input logic [31:0] v);
        logic [31:0]     w;
        logic [ZC_W-1:0] n;
        w = v;
        n = '0;
        if (w[31:16] == 16'd0) begin n = n + ZC_W'(16); w = w << 16; end
        if (w[31:24] == 8'd0)  begin n = n + ZC_W'(8);  w = w << 8;  end
        if (w[31:28] == 4'd0)  begin n = n + ZC_W'(4);  w = w << 4;  end
        if (w[31:30] == 2'd0)  begin n = n + ZC_W'(2);  w = w << 2;  end
        if (w[31] == 1'b0)     begin n = n + ZC_W'(1);               end
        return n;
    endfunction

    // trailing zeros of a non-zero word, halving search
    function automatic logic [ZC_W-1:0] count_trail(input logic [31:0] v);
        logic [31:0]     w;
        logic [ZC_W-1:0] n;
        w = v;
        n = '0;
        if (w[15:0] == 16'd0) begin n = n + ZC_W'(16); w = w >> 16; end
        if (w[7:0] == 8'd0)   begin n = n + ZC_W'(8);  w = w >> 8;  end
        if (w[3:0] == 4'd0)   begin n = n + ZC_W'(4);  w = w >> 4;  end
        if (w[1:0] == 2'd0)   begin n = n + ZC_W'(2);  w = w >> 2;  end
        if (w[0] == 1'b0)     begin n = n + ZC_W'(1);               end
        return n;
    endfunction

    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    // classification
    assign xor_val  = in_data.value_bits ^ prev_reg;
    assign lz       = count_lead(xor_val);
    assign tz       = count_trail(xor_val);
    assign mean_len = ZC_W'(32) - lz - tz;
    assign win_len  = ZC_W'(32) - win_lead_reg - win_trail_reg;
    assign win_hit  = (win_lead_reg != NO_WINDOW) && (win_trail_reg != NO_WINDOW)
                      && (lz >= win_lead_reg) && (tz >= win_trail_reg);
    assign new_window = !in_data.block_start && (xor_val != 32'd0) && !win_hit;

    // codeword build
    always_comb
    begin
        push_data.block_start = in_data.block_start;
        push_data.block_end   = in_data.block_end;
        if (in_data.block_start)
        begin
            push_data.code = CODE_W'(in_data.value_bits);
            push_data.len  = LEN_W'(32);
        end
        else if (xor_val == 32'd0)
        begin
            push_data.code = '0;
            push_data.len  = LEN_W'(1);
        end
        else if (win_hit)
        begin
            push_data.code = (CODE_W'(xor_val >> win_trail_reg) << 2) | CODE_W'(1);
            push_data.len  = LEN_W'(2) + LEN_W'(win_len);
        end
        else
        begin
            push_data.code = (CODE_W'(xor_val >> tz) << 12)
                           | (CODE_W'(mean_len - ZC_W'(1)) << 7)
                           | (CODE_W'(lz) << 2)
                           | CODE_W'(3);
            push_data.len  = LEN_W'(12) + LEN_W'(mean_len);
        end
    end

    // previous value and window tracking
    always_comb
    begin
        prev_next      = prev_reg;
        win_lead_next  = win_lead_reg;
        win_trail_next = win_trail_reg;
        if (push)
        begin
            if (in_data.block_end)
            begin
                prev_next      = '0;
                win_lead_next  = NO_WINDOW;
                win_trail_next = NO_WINDOW;
            end
            else
            begin
                prev_next = in_data.value_bits;
                if (in_data.block_start)
                begin
                    win_lead_next  = NO_WINDOW;
                    win_trail_next = NO_WINDOW;
                end
                else if (new_window)
                begin
                    win_lead_next  = lz;
                    win_trail_next = tz;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= '0;
            win_lead_reg  <= NO_WINDOW;
            win_trail_reg <= NO_WINDOW;
        end
        else
        begin
            prev_reg      <= prev_next;
            win_lead_reg  <= win_lead_next;
            win_trail_reg <= win_trail_next;
        end
    end

endmodule

// ----- src/fxe_queue.sv -----
// ----------------------------------------------------------------------------
// fxe_queue
// Short codeword queue between the front end and the packer.
// ----------------------------------------------------------------------------
module fxe_queue
    import fxe_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_data,
    output logic   full,
    input  logic   pop,
    output logic   not_empty,
    output entry_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_Q_W = $clog2(DEPTH + 1);

    entry_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_Q_W-1:0] count_reg;
    logic [CNT_Q_W-1:0] count_next;

    assign full      = (count_reg == CNT_Q_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    // pointer and fill tracking
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_Q_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_Q_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- src/fxe_packer.sv -----
// ----------------------------------------------------------------------------
// fxe_packer
// Back end: packs codewords lsb-first into bytes, enforces the output
// capacity, flushes the partial byte and emits the block status.
// ----------------------------------------------------------------------------
module fxe_packer
    import fxe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CNT_W-1:0] capacity,
    input  logic             q_not_empty,
    input  entry_t           q_head,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output out_t             out_data
);

    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  acc_next;
    logic [PEND_W-1:0] pend_reg;
    logic [PEND_W-1:0] pend_next;
    logic [CNT_W-1:0]  bytes_reg;
    logic [CNT_W-1:0]  bytes_next;
    logic              ovf_reg;
    logic              ovf_next;
    logic              end_pend_reg;
    logic              end_pend_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    out_t              out_data_reg;

    logic              out_free;
    logic              emit;
    out_t              emit_data;
    logic              full_byte;
    logic              no_room;

    assign out_free  = !out_valid_reg || !out_stall;
    assign full_byte = (pend_reg >= PEND_W'(8)) && !ovf_reg;
    assign no_room   = (bytes_reg >= capacity);

    // byte drain, flush and status, then take the next codeword
    always_comb
    begin
        acc_next      = acc_reg;
        pend_next     = pend_reg;
        bytes_next    = bytes_reg;
        ovf_next      = ovf_reg;
        end_pend_next = end_pend_reg;
        pop           = 1'b0;
        emit          = 1'b0;
        emit_data     = '0;
        if (full_byte)
        begin
            if (no_room)
            begin
                ovf_next = 1'b1;
            end
            else if (out_free)
            begin
                emit                 = 1'b1;
                emit_data.out_byte   = acc_reg[7:0];
                emit_data.byte_valid = 1'b1;
                acc_next             = acc_reg >> 8;
                pend_next            = pend_reg - PEND_W'(8);
                bytes_next           = bytes_reg + CNT_W'(1);
            end
        end
        else if (end_pend_reg)
        begin
            if (!ovf_reg && (pend_reg != '0))
            begin
                // partial byte flush
                if (no_room)
                begin
                    ovf_next = 1'b1;
                end
                else if (out_free)
                begin
                    emit                 = 1'b1;
                    emit_data.out_byte   = acc_reg[7:0];
                    emit_data.byte_valid = 1'b1;
                    acc_next             = '0;
                    pend_next            = '0;
                    bytes_next           = bytes_reg + CNT_W'(1);
                end
            end
            else if (out_free)
            begin
                // block status, then back to a clean state
                emit                 = 1'b1;
                emit_data.block_done = 1'b1;
                emit_data.byte_count = bytes_reg;
                emit_data.too_small  = ovf_reg;
                acc_next             = '0;
                pend_next            = '0;
                bytes_next           = '0;
                ovf_next             = 1'b0;
                end_pend_next        = 1'b0;
            end
        end
        else if (q_not_empty)
        begin
            pop           = 1'b1;
            end_pend_next = q_head.block_end;
            if (q_head.block_start)
            begin
                acc_next   = ACC_W'(q_head.code);
                pend_next  = PEND_W'(q_head.len);
                bytes_next = '0;
                ovf_next   = 1'b0;
            end
            else if (!ovf_reg)
            begin
                acc_next  = acc_reg | (ACC_W'(q_head.code) << pend_reg[2:0]);
                pend_next = pend_reg + PEND_W'(q_head.len);
            end
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            pend_reg      <= '0;
            bytes_reg     <= '0;
            ovf_reg       <= 1'b0;
            end_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            pend_reg      <= pend_next;
            bytes_reg     <= bytes_next;
            ovf_reg       <= ovf_next;
            end_pend_reg  <= end_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg <= emit_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- src/float_xor_stream_encoder_unit.sv -----
// ----------------------------------------------------------------------------
// float_xor_stream_encoder_unit
// Xor compression of float32 bit patterns, bytes packed lsb-first.
// ----------------------------------------------------------------------------
// The front end takes one value per cycle while the codeword queue has room
// and turns it into a codeword in the same cycle. The packer takes a codeword
// from the queue and then drains each whole byte it yields (up to six) before
// taking the next; a block end adds a partial byte, if one is left, and the
// status transfer. Once a block reaches the capacity, the packer marks the
// overflow, drops the block's remaining bytes and flags too_small in the status.
// The output register lets the packer take in a codeword while the last byte
// waits on out_stall, as long as no whole byte is pending. output_capacity sits
// at byte address 0 and must only be written while the encoder is idle.
module float_xor_stream_encoder_unit
    import fxe_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // value stream
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_t                   in_data,
    // byte stream
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_t                  out_data,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [CNT_W-1:0] capacity_reg;
    logic [CNT_W-1:0] capacity_next;
    logic             push;
    entry_t           push_data;
    logic             queue_full;
    logic             pop;
    logic             q_not_empty;
    entry_t           q_head;

    // configuration register
    assign pready = 1'b1;

    always_comb
    begin
        capacity_next = capacity_reg;
        if (psel && penable && pwrite && (paddr[2] == REG_OUTPUT_CAPACITY))
        begin
            capacity_next = pwdata[CNT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_OUTPUT_CAPACITY)
        begin
            prdata = APB_DATA_W'(capacity_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
        end
        else
        begin
            capacity_reg <= capacity_next;
        end
    end

    // classify and build codewords
    fxe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .push       (push),
        .push_data  (push_data),
        .queue_full (queue_full)
    );

    // codeword queue
    fxe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // bit packing and status
    fxe_packer u_packer (
        .clk         (clk),
        .rst_n       (rst_n),
        .capacity    (capacity_reg),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the float xor stream encoder. Values are offered
// from a queue with random gaps. Every accepted value runs through a local
// encoder model that queues the bytes and the status transfer it should
// produce. Each transfer taken from the byte stream is checked field by field
// against the oldest queued result. Phases at several capacities cover
// overflow, flush without room and the ordinary coding paths.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import fxe_pkg::*;

    localparam int HOLD_OFF_CYCLES = 150;
    localparam int SETTLE_CYCLES   = 20;
    localparam int MAX_REPORTS     = 10;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    in_t                   in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_t                  out_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // values waiting to be offered, and results still owed by the encoder
    in_t  value_queue[$];
    out_t expected_bytes[$];

    int   fail_count = 0;
    logic in_fired = 1'b0;
    int   sender_idle_pct = 0;
    int   receiver_idle_pct = 0;
    logic hold_off_req = 1'b0;

    // receiver hold-off countdown
    int   hold_left = 0;
    logic hold_done = 1'b0;

    // encoder model state
    logic [15:0] byte_limit = CAPACITY_RESET;
    logic [31:0] prev_value;
    int          win_lead;
    int          win_trail;
    logic [63:0] bit_buffer;
    int          pend_bits;
    int          bytes_out;
    logic        overflowed;

    float_xor_stream_encoder_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2_400_000;
        $display("testbench: errors");
        $finish;
    end

    function automatic int lead_zero_count(input logic [31:0] v);
        int n;
        n = 0;
        while (n < 32 && !v[31 - n])
            n++;
        return n;
    endfunction

    function automatic int trail_zero_count(input logic [31:0] v);
        int n;
        n = 0;
        while (n < 32 && !v[n])
            n++;
        return n;
    endfunction

    function automatic void clear_encoder();
        prev_value = '0;
        win_lead   = 32;
        win_trail  = 32;
        bit_buffer = '0;
        pend_bits  = 0;
        bytes_out  = 0;
        overflowed = 1'b0;
    endfunction

    function automatic void queue_result(input logic [7:0] data, input logic valid,
                                         input logic done, input int count,
                                         input logic small_flag);
        out_t r;
        r.out_byte   = data;
        r.byte_valid = valid;
        r.block_done = done;
        r.byte_count = 16'(count);
        r.too_small  = small_flag;
        expected_bytes.push_back(r);
    endfunction

    // append a codeword lsb-first and release every whole byte that fits
    function automatic void shift_in_bits(input logic [63:0] code, input int n);
        if (overflowed)
            return;
        bit_buffer = bit_buffer | (code << pend_bits);
        pend_bits += n;
        while (pend_bits >= 8)
        begin
            if (bytes_out >= int'(byte_limit))
            begin
                overflowed = 1'b1;
                return;
            end
            queue_result(bit_buffer[7:0], 1'b1, 1'b0, 0, 1'b0);
            bytes_out++;
            bit_buffer = bit_buffer >> 8;
            pend_bits -= 8;
        end
    endfunction

    // code one accepted value and queue the transfers it causes
    function automatic void encode_value(input in_t item);
        logic [31:0] diff;
        logic [63:0] code;
        int          lz;
        int          tz;
        int          width;
        if (item.block_start)
        begin
            clear_encoder();
            shift_in_bits({32'b0, item.value_bits}, 32);
        end
        else
        begin
            diff = item.value_bits ^ prev_value;
            if (diff == '0)
                shift_in_bits(64'd0, 1);
            else
            begin
                lz = lead_zero_count(diff);
                tz = trail_zero_count(diff);
                if (lz >= win_lead && tz >= win_trail && win_lead < 32 && win_trail < 32)
                begin
                    // old window still covers the change
                    width = 32 - win_lead - win_trail;
                    code  = 64'd1 | (64'(diff >> win_trail) << 2);
                    shift_in_bits(code, 2 + width);
                end
                else
                begin
                    // new window with lead count and length
                    width = 32 - lz - tz;
                    code  = 64'd3 | (64'(lz) << 2) | (64'(width - 1) << 7)
                            | (64'(diff >> tz) << 12);
                    shift_in_bits(code, 12 + width);
                    win_lead  = lz;
                    win_trail = tz;
                end
            end
        end
        prev_value = item.value_bits;
        if (item.block_end)
        begin
            if (!overflowed && pend_bits > 0)
            begin
                if (bytes_out >= int'(byte_limit))
                    overflowed = 1'b1;
                else
                begin
                    queue_result(bit_buffer[7:0], 1'b1, 1'b0, 0, 1'b0);
                    bytes_out++;
                end
            end
            queue_result(8'h00, 1'b0, 1'b1, bytes_out, overflowed);
            clear_encoder();
        end
    endfunction

    // value driver: a new transfer is offered once the previous one is taken
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_fired))
        begin
            if (value_queue.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                in_data  <= value_queue.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // byte receiver: random stalls plus one long hold-off
    always @(negedge clk)
    begin : receiver
        if (hold_off_req && !hold_done)
        begin
            hold_left = HOLD_OFF_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
    end

    // monitor: model accepted values, check accepted bytes
    always @(posedge clk)
    begin : monitor
        out_t want;
        in_fired <= in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
            encode_value(in_data);
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_bytes.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected transfer: byte %02h valid %0d done %0d count %0d small %0d",
                             out_data.out_byte, out_data.byte_valid, out_data.block_done,
                             out_data.byte_count, out_data.too_small);
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (out_data.out_byte !== want.out_byte
                    || out_data.byte_valid !== want.byte_valid
                    || out_data.block_done !== want.block_done
                    || out_data.byte_count !== want.byte_count
                    || out_data.too_small !== want.too_small)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display({"mismatch: byte %02h/%02h valid %0d/%0d done %0d/%0d ",
                                  "count %0d/%0d small %0d/%0d (expected/actual)"},
                                 want.out_byte, out_data.out_byte,
                                 want.byte_valid, out_data.byte_valid,
                                 want.block_done, out_data.block_done,
                                 want.byte_count, out_data.byte_count,
                                 want.too_small, out_data.too_small);
                end
            end
        end
    end

    task automatic push_value(input logic [31:0] v, input logic s, input logic e);
        in_t item;
        item.value_bits  = v;
        item.block_start = s;
        item.block_end   = e;
        value_queue.push_back(item);
    endtask

    // register write: setup cycle then access cycle
    task automatic write_capacity(input logic [15:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(REG_OUTPUT_CAPACITY) << 2;
        pwdata  <= {16'b0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        byte_limit = value;
    endtask

    // wait until every value is taken and every result has arrived
    task automatic drain();
        while (value_queue.size() != 0 || in_valid || expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one block of values that mostly drift inside a random bit range, with some fresh random and fixed corner values
    task automatic queue_block(input int count, input logic with_start, input logic with_end);
        logic [31:0] v;
        logic [31:0] mask;
        int          lo;
        int          hi;
        lo   = $urandom_range(0, 24);
        hi   = $urandom_range(lo, 31);
        mask = (32'hFFFF_FFFF >> (31 - hi)) & (32'hFFFF_FFFF << lo);
        v    = $urandom;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1: ;
                2: v = $urandom;
                3:
                begin
                    case ($urandom_range(0, 3))
                        0: v = 32'h0000_0000;
                        1: v = 32'hFFFF_FFFF;
                        2: v = 32'h8000_0000;
                        default: v = 32'h0000_0001;
                    endcase
                end
                default: v = v ^ ($urandom & mask);
            endcase
            push_value(v, with_start && i == 0, with_end && i == count - 1);
        end
    endtask

    // mostly well-formed blocks, some missing a start or an end mark
    task automatic queue_phase(input int total);
        int made;
        int n;
        int pick;
        made = 0;
        while (made < total)
        begin
            n = $urandom_range(1, 12);
            if (n > total - made)
                n = total - made;
            pick = $urandom_range(0, 9);
            queue_block(n, pick != 0, pick != 1 || made + n >= total);
            made += n;
        end
    endtask

    // main sequence
    initial
    begin
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        clear_encoder();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        sender_idle_pct   = 14;
        receiver_idle_pct = 70;

        // raw start, unchanged, full-width window, window reuse, block end
        push_value(32'h0000_0000, 1'b1, 1'b0);
        push_value(32'h0000_0000, 1'b0, 1'b0);
        push_value(32'hFFFF_FFFF, 1'b0, 1'b0);
        push_value(32'h0000_0000, 1'b0, 1'b0);
        push_value(32'h8000_0000, 1'b0, 1'b0);
        push_value(32'h8000_0001, 1'b0, 1'b0);
        push_value(32'h3F80_0000, 1'b0, 1'b1);
        // values with no start after a block end
        push_value(32'h4049_0FDB, 1'b0, 1'b0);
        push_value(32'h4049_0FDB, 1'b0, 1'b0);
        push_value(32'h4049_0FDA, 1'b0, 1'b0);
        // start inside a block, then both marks on one value
        push_value(32'h1234_5678, 1'b1, 1'b0);
        push_value(32'h1234_5679, 1'b0, 1'b0);
        push_value(32'hDEAD_BEEF, 1'b1, 1'b1);
        // end mark without a start
        push_value(32'h7F80_0000, 1'b0, 1'b1);
        drain();

        // capacity reached mid-value
        write_capacity(16'd3);
        push_value(32'h0102_0304, 1'b1, 1'b0);
        push_value(32'h0102_0304, 1'b0, 1'b1);
        drain();
        // partial byte with no room left at the end
        write_capacity(16'd4);
        push_value(32'hA5A5_A5A5, 1'b1, 1'b0);
        push_value(32'hA5A5_A5A5, 1'b0, 1'b1);
        drain();
        // no room at all
        write_capacity(16'd0);
        push_value(32'hFFFF_FFFF, 1'b1, 1'b1);
        drain();

        // small capacity, long receiver hold-off
        write_capacity(16'($urandom_range(8, 60)));
        hold_off_req = 1'b1;
        queue_phase(38);
        drain();

        sender_idle_pct   = 70;
        receiver_idle_pct = 14;
        write_capacity(16'hFFFF);
        queue_phase(38);
        drain();

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        write_capacity(16'($urandom_range(0, 65535)));
        queue_phase(35);
        drain();

        if (fail_count == 0 && expected_bytes.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
